// File: sv/ftc_pkg.sv
// Shared types and constants for the frequency threshold hash counter.
package ftc_pkg;

   localparam int VALUE_W          = 32;
   localparam int DIVISOR_W        = 11;
   localparam int MAX_DISTINCT_DEF = 32;
   localparam int MAX_ITEMS_DEF    = 1024;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      is_last;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] result_value;
      logic                      found;
      logic                      overflow;
      logic                      last_result;
   } rsp_type;

   typedef struct packed {
      logic absorb;
      logic div_start;
      logic advance;
      logic load_pend;
      logic push_mid;
      logic push_final;
   } cmd_type;

   typedef struct packed {
      logic idx_done;
      logic qualify;
      logic pend_vld;
      logic slot_free;
      logic div_busy;
   } sts_type;

endpackage

// File: sv/ftc_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
module ftc_divider #(
   parameter int NW = 11
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [NW-1:0]                  dividend,
   input  logic [ftc_pkg::DIVISOR_W-1:0]  divisor,
   output logic                           busy,
   output logic [NW-1:0]                  quotient
);
   import ftc_pkg::*;

   localparam int CW = $clog2(NW + 1);

   logic [CW-1:0]        iter_ff, iter_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [NW-1:0]        quo_ff, quo_in;
   logic [DIVISOR_W:0]   shifted;
   logic [DIVISOR_W:0]   diff;
   logic                 ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[NW-1]};
      diff    = shifted - {1'b0, divisor};
      ge      = shifted >= {1'b0, divisor};
      iter_in = iter_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         iter_in = CW'(NW);
         rem_in  = '0;
         quo_in  = dividend;
      end else if (iter_ff != '0) begin
         iter_in = iter_ff - 1'b1;
         rem_in  = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         quo_in  = {quo_ff[NW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iter_ff <= '0;
      end else begin
         iter_ff <= iter_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy     = iter_ff != '0;
   assign quotient = quo_ff;

endmodule

// File: sv/ftc_datapath.sv
// Value table, counters, threshold divider, scan and output register.
module ftc_datapath #(
   parameter int MAX_DISTINCT = ftc_pkg::MAX_DISTINCT_DEF,
   parameter int MAX_ITEMS    = ftc_pkg::MAX_ITEMS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ftc_pkg::req_type              req_data,
   input  logic                          csr_we,
   input  logic [ftc_pkg::DIVISOR_W-1:0] csr_wdata,
   input  ftc_pkg::cmd_type              cmd,
   output ftc_pkg::sts_type              sts,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output ftc_pkg::rsp_type              rsp_data
);
   import ftc_pkg::*;

   localparam int NW = $clog2(MAX_ITEMS + 1);
   localparam int EW = $clog2(MAX_DISTINCT + 1);
   localparam int IW = $clog2(MAX_DISTINCT);

   logic signed [VALUE_W-1:0] val_ff [MAX_DISTINCT];
   logic [NW-1:0]             cnt_ff [MAX_DISTINCT];
   logic [MAX_DISTINCT-1:0]   hit;

   logic [EW-1:0]             used_ff, used_in;
   logic [NW-1:0]             items_ff, items_in;
   logic                      ovf_ff, ovf_in;
   logic [EW-1:0]             idx_ff, idx_in;
   logic                      pend_vld_ff, pend_vld_in;
   logic signed [VALUE_W-1:0] pend_val_ff, pend_val_in;
   logic [DIVISOR_W-1:0]      divisor_ff, divisor_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   logic                      any_hit;
   logic                      items_full;
   logic                      table_full;
   logic [DIVISOR_W-1:0]      div_eff;
   logic                      div_busy;
   logic [NW-1:0]             threshold;
   logic signed [VALUE_W-1:0] sel_val;
   logic [NW-1:0]             sel_cnt;

   assign any_hit    = |hit;
   assign items_full = items_ff == NW'(MAX_ITEMS);
   assign table_full = used_ff == EW'(MAX_DISTINCT);
   assign div_eff    = (divisor_ff == '0) ? DIVISOR_W'(1) : divisor_ff;

   for (genvar i = 0; i < MAX_DISTINCT; i++) begin : g_entry
      assign hit[i] = (EW'(i) < used_ff) && (val_ff[i] == req_data.value);

      always_ff @(posedge clock) begin
         if (cmd.absorb && !items_full) begin
            if (hit[i]) begin
               cnt_ff[i] <= cnt_ff[i] + 1'b1;
            end else if (!any_hit && used_ff == EW'(i)) begin
               val_ff[i] <= req_data.value;
               cnt_ff[i] <= NW'(1);
            end
         end
      end
   end

   ftc_divider #(
      .NW (NW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (items_ff),
      .divisor  (div_eff),
      .busy     (div_busy),
      .quotient (threshold)
   );

   assign sel_val = val_ff[idx_ff[IW-1:0]];
   assign sel_cnt = cnt_ff[idx_ff[IW-1:0]];

   always_comb begin
      used_in      = used_ff;
      items_in     = items_ff;
      ovf_in       = ovf_ff;
      idx_in       = idx_ff;
      pend_vld_in  = pend_vld_ff;
      pend_val_in  = pend_val_ff;
      divisor_in   = csr_we ? csr_wdata : divisor_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      // absorb one item
      if (cmd.absorb) begin
         if (items_full) begin
            ovf_in = 1'b1;
         end else begin
            items_in = items_ff + 1'b1;
            if (!any_hit) begin
               if (table_full) begin
                  ovf_in = 1'b1;
               end else begin
                  used_in = used_ff + 1'b1;
               end
            end
         end
      end

      if (cmd.advance) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.load_pend) begin
         pend_vld_in = 1'b1;
         pend_val_in = sel_val;
      end

      // output beat
      if (cmd.push_mid) begin
         rsp_valid_in        = 1'b1;
         rsp_in.result_value = pend_val_ff;
         rsp_in.found        = 1'b1;
         rsp_in.overflow     = ovf_ff;
         rsp_in.last_result  = 1'b0;
      end else if (cmd.push_final) begin
         rsp_valid_in        = 1'b1;
         rsp_in.result_value = pend_vld_ff ? pend_val_ff : '0;
         rsp_in.found        = pend_vld_ff;
         rsp_in.overflow     = ovf_ff;
         rsp_in.last_result  = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // clear the set
      if (cmd.push_final) begin
         used_in     = '0;
         items_in    = '0;
         ovf_in      = 1'b0;
         idx_in      = '0;
         pend_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         items_ff     <= '0;
         ovf_ff       <= 1'b0;
         idx_ff       <= '0;
         pend_vld_ff  <= 1'b0;
         divisor_ff   <= DIVISOR_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         items_ff     <= items_in;
         ovf_ff       <= ovf_in;
         idx_ff       <= idx_in;
         pend_vld_ff  <= pend_vld_in;
         divisor_ff   <= divisor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_val_ff <= pend_val_in;
      rsp_ff      <= rsp_in;
   end

   assign sts.idx_done  = idx_ff == used_ff;
   assign sts.qualify   = sel_cnt > threshold;
   assign sts.pend_vld  = pend_vld_ff;
   assign sts.slot_free = !rsp_valid_ff || rsp_ready;
   assign sts.div_busy  = div_busy;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: sv/ftc_controller.sv
// Sequencer for load, threshold divide and result scan.
module ftc_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_is_last,
   output logic             req_ready,
   input  ftc_pkg::sts_type sts,
   output ftc_pkg::cmd_type cmd
);
   import ftc_pkg::*;

   localparam logic [1:0] S_LOAD  = 2'd0;
   localparam logic [1:0] S_START = 2'd1;
   localparam logic [1:0] S_DIV   = 2'd2;
   localparam logic [1:0] S_SCAN  = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.absorb = 1'b1;
               if (req_is_last) begin
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (!sts.div_busy) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (!sts.idx_done) begin
               if (sts.qualify) begin
                  if (sts.pend_vld) begin
                     if (sts.slot_free) begin
                        cmd.push_mid  = 1'b1;
                        cmd.load_pend = 1'b1;
                        cmd.advance   = 1'b1;
                     end
                  end else begin
                     cmd.load_pend = 1'b1;
                     cmd.advance   = 1'b1;
                  end
               end else begin
                  cmd.advance = 1'b1;
               end
            end else if (sts.slot_free) begin
               cmd.push_final = 1'b1;
               state_in       = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: sv/frequency_threshold_hash_count.sv
// Top level of the frequency threshold hash counter.
//
//   port group   direction   beat
//   req_         in          one value of the set, is_last on the final one
//   rsp_         out         one qualifying value, last_result on the final one
//   csr_         in          divisor write, no handshake
//
// Items are taken one per cycle while the block loads a set; the value table
// compares all entries at once. After the last item the controller issues a
// start, waits while the iterative divider runs, then scans one table entry
// at a time and sends the final beat.
// The scan holds a push while the output register is full and rsp_ready is low.
// Reset is synchronous and clears the set and sets the divisor to 1.
module frequency_threshold_hash_count #(
   parameter int MAX_DISTINCT = ftc_pkg::MAX_DISTINCT_DEF,
   parameter int MAX_ITEMS    = ftc_pkg::MAX_ITEMS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  ftc_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output ftc_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [ftc_pkg::DIVISOR_W-1:0] csr_wdata
);
   import ftc_pkg::*;

   cmd_type cmd;
   sts_type sts;

   ftc_controller u_controller (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_is_last (req_data.is_last),
      .req_ready   (req_ready),
      .sts         (sts),
      .cmd         (cmd)
   );

   ftc_datapath #(
      .MAX_DISTINCT (MAX_DISTINCT),
      .MAX_ITEMS    (MAX_ITEMS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_push_needs_slot : assert property (@(posedge clock) disable iff (reset)
      (cmd.push_mid || cmd.push_final) |-> sts.slot_free)
      else $error("result pushed into a full output register");

   a_final_marks_last : assert property (@(posedge clock) disable iff (reset)
      cmd.push_final |=> rsp_valid && rsp_data.last_result)
      else $error("final result beat lacks last_result");

   a_not_found_is_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.found) |-> rsp_data.last_result)
      else $error("empty result beat is not the final one");

   a_load_not_dividing : assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !sts.div_busy)
      else $error("items accepted while threshold divide runs");

endmodule

// File: verif/tb_frequency_threshold_hash_count.sv
`timescale 1ns / 100ps
// Testbench for the frequency threshold hash counter with a table predictor.
module tb_frequency_threshold_hash_count;
   import ftc_pkg::*;

   localparam int MAX_DIST    = MAX_DISTINCT_DEF;
   localparam int MAX_COUNT   = MAX_ITEMS_DEF;
   localparam int DRAIN_CYC   = 80;
   localparam int CYCLE_LIMIT = 200000;
   localparam int IDLE_PCT    = 31;
   localparam int PHASES      = 6;

   logic                 clock;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we    = 1'b0;
   logic [DIVISOR_W-1:0] csr_wdata = '0;

   // table predictor state
   logic [VALUE_W-1:0]   seen_value [MAX_DIST];
   logic [DIVISOR_W-1:0] seen_count [MAX_DIST];
   logic [5:0]           used_entries = '0;
   logic [DIVISOR_W-1:0] set_items    = '0;
   logic                 set_overflow = 1'b0;
   logic [DIVISOR_W-1:0] divisor_q    = 11'd1;
   rsp_type              pending_hits [$];

   rsp_type want_beat;
   rsp_type got_beat;
   logic    no_gaps      = 1'b0;
   int      mismatches   = 0;
   int      items_sent   = 0;
   int      sets_sent    = 0;
   int      results_seen = 0;
   int      cycle_count  = 0;

   frequency_threshold_hash_count dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic void count_value(input logic [VALUE_W-1:0] v);
      bit hit;
      hit = 1'b0;
      if (set_items >= MAX_COUNT) begin
         set_overflow = 1'b1;
         return;
      end
      set_items++;
      for (int i = 0; i < used_entries; i++) begin
         if (!hit && seen_value[i] == v) begin
            seen_count[i]++;
            hit = 1'b1;
         end
      end
      if (!hit) begin
         if (used_entries < MAX_DIST) begin
            seen_value[used_entries] = v;
            seen_count[used_entries] = 11'd1;
            used_entries++;
         end else begin
            set_overflow = 1'b1;
         end
      end
   endfunction

   function automatic void emit_hits();
      logic [DIVISOR_W-1:0] k;
      logic [DIVISOR_W-1:0] thr;
      rsp_type              hit;
      int                   n;
      k   = (divisor_q == '0) ? 11'd1 : divisor_q;
      thr = set_items / k;
      n   = 0;
      for (int i = 0; i < used_entries; i++) begin
         if (seen_count[i] > thr) begin
            hit.result_value = seen_value[i];
            hit.found        = 1'b1;
            hit.overflow     = set_overflow;
            hit.last_result  = 1'b0;
            pending_hits     = {pending_hits, hit};
            n++;
         end
      end
      if (n == 0) begin
         hit             = '0;
         hit.overflow    = set_overflow;
         hit.last_result = 1'b1;
         pending_hits    = {pending_hits, hit};
      end else begin
         hit             = pending_hits.pop_back();
         hit.last_result = 1'b1;
         pending_hits    = {pending_hits, hit};
      end
      used_entries = '0;
      set_items    = '0;
      set_overflow = 1'b0;
   endfunction

   always @(negedge clock)
      rsp_ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_beat = rsp_data;
         if (pending_hits.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat at cycle %0d: value %h found %b ovf %b last %b",
                        cycle_count, got_beat.result_value, got_beat.found,
                        got_beat.overflow, got_beat.last_result);
         end else begin
            want_beat = pending_hits.pop_front();
            results_seen++;
            if (got_beat.result_value !== want_beat.result_value ||
                got_beat.found !== want_beat.found ||
                got_beat.overflow !== want_beat.overflow ||
                got_beat.last_result !== want_beat.last_result) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch at cycle %0d: expected value %h found %b ovf %b last %b,",
                            " got value %h found %b ovf %b last %b"},
                           cycle_count, want_beat.result_value, want_beat.found,
                           want_beat.overflow, want_beat.last_result,
                           got_beat.result_value, got_beat.found,
                           got_beat.overflow, got_beat.last_result);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_hits.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic send_beat(input logic [VALUE_W-1:0] v, input logic last);
      req_type beat;
      beat.value   = v;
      beat.is_last = last;
      if (!no_gaps) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      count_value(v);
      if (last) emit_hits();
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_set(input logic [VALUE_W-1:0] vals [$]);
      foreach (vals[i]) send_beat(vals[i], i == vals.size() - 1);
      sets_sent++;
   endtask

   // drop valid, drain expected results, then let the scan finish
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_hits.size() != 0) @(negedge clock);
      repeat (DRAIN_CYC) @(negedge clock);
   endtask

   task automatic set_divisor(input logic [DIVISOR_W-1:0] d);
      settle();
      csr_we    <= 1'b1;
      csr_wdata <= d;
      @(negedge clock);
      csr_we    <= 1'b0;
      divisor_q = d;
      @(negedge clock);
   endtask

   task automatic test_default_divisor();
      send_set('{32'd5, 32'd5, 32'd5});
      send_set('{32'd7});
   endtask

   task automatic test_value_extremes();
      set_divisor(11'd2047);
      send_set('{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                 32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000, 32'hFFFF_FFFF});
      send_set('{32'h1234_5678});
   endtask

   task automatic test_divisor_edges();
      set_divisor(11'd0);
      send_set('{32'd1, 32'd1, 32'd2});
      set_divisor(11'd2);
      send_set('{32'd9, 32'd9, 32'd9, 32'd4});
      set_divisor(11'd1024);
      send_set('{32'd3, 32'd3});
   endtask

   task automatic test_table_full();
      logic [VALUE_W-1:0] vals [$];
      logic [VALUE_W-1:0] base;
      base = $urandom();
      set_divisor(11'd1024);
      for (int i = 0; i < MAX_DIST; i++) vals = {vals, base + i * 32'h9E37_79B9};
      vals = {vals, base};
      send_set(vals);
      vals.delete();
      for (int i = 0; i < MAX_DIST + 8; i++) vals = {vals, base + i * 32'h9E37_79B9};
      send_set(vals);
      set_divisor(11'd1);
      vals.delete();
      for (int i = 0; i < MAX_DIST + 3; i++) vals = {vals, ~base + i * 32'h9E37_79B9};
      send_set(vals);
   endtask

   task automatic test_random_sets();
      logic [DIVISOR_W-1:0] phase_div [PHASES];
      logic [VALUE_W-1:0]   pool [8];
      logic [VALUE_W-1:0]   vals [$];
      int                   budget;
      int                   len;
      int                   ps;
      phase_div = '{11'd2, 11'd3, 11'd5, 11'd1, 11'd4, 11'd0};
      phase_div[PHASES-1] = DIVISOR_W'($urandom_range(0, 2047));
      for (int p = 0; p < PHASES; p++) begin
         set_divisor(phase_div[p]);
         no_gaps = (p == 2);
         budget  = 25;
         while (budget > 0) begin
            ps = $urandom_range(1, 6);
            for (int j = 0; j < 8; j++)
               pool[j] = $urandom_range(1) ? $urandom() : VALUE_W'($urandom_range(0, 15)) - 8;
            len = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
            vals.delete();
            for (int j = 0; j < len; j++)
               vals = {vals, ($urandom_range(99) < 15) ? $urandom() : pool[$urandom_range(ps - 1)]};
            send_set(vals);
            budget -= len;
         end
         no_gaps = 1'b0;
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_default_divisor();
      test_value_extremes();
      test_divisor_edges();
      test_table_full();
      test_random_sets();
      settle();
      $display("ran %0d sets with %0d input beats and checked %0d result beats",
               sets_sent, items_sent, results_seen);
      $display("covered divisors 0 to 2047, value extremes and a full value table");
      if (pending_hits.size() != 0)
         $display("%0d expected results never arrived", pending_hits.size());
      if (mismatches == 0 && pending_hits.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
